// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked during reset too
`define ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/gcs_pkg.sv =====
`timescale 1ns / 1ps
package gcs_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_BITS      = $clog2(PALETTE_DEPTH);
    localparam int COORD_BITS    = 12;
    localparam int SQRT_STEPS    = 23;
    localparam int DIV_STEPS     = 8;
    localparam int LATENCY       = 5 + SQRT_STEPS + DIV_STEPS + 1;

    localparam logic MODE_RADIAL = 1'b0;
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        CFG_MODE   = 3'd0,
        CFG_FX     = 3'd1,
        CFG_FY     = 3'd2,
        CFG_RADIUS = 3'd3,
        CFG_SX     = 3'd4,
        CFG_SY     = 3'd5,
        CFG_COUNT  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic [14:0]        radius;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [8:0]         count;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic                func;
        logic [IDX_BITS-1:0] eidx;
        logic [7:0]          esym;
    } t_ctl;

    typedef struct packed {
        t_ctl        ctl;
        logic        use_sqrt;
        logic        done;
        logic        degen;
        logic [7:0]  idx;
        logic [45:0] sq_v;
        logic [45:0] sq_res;
        logic [45:0] sq_bit;
        logic [41:0] num;
        logic [41:0] dsh;
    } t_item;

endpackage

// ===== rtl/gcs_front.sv =====
`timescale 1ns / 1ps
module gcs_front import gcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    input  logic                  i_func,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic [IDX_BITS-1:0]   i_entry_index,
    input  logic [7:0]            i_entry_symbol,
    output t_item                 o_item
);

    t_ctl               r_a_ctl, r_b_ctl, r_c_ctl, r_d_ctl;
    logic signed [17:0] r_a_dx, r_a_dy, r_a_bx, r_a_by;
    logic signed [35:0] r_b_pa, r_b_pb, r_b_pc, r_b_pd;
    logic [29:0]        r_b_rr, r_c_rr;
    logic [15:0]        r_b_mm, r_c_mm, r_d_mm;
    logic [7:0]         r_b_m, r_c_m, r_d_m;
    logic signed [36:0] r_c_s1, r_c_s2;
    logic               r_d_done, r_d_degen, r_d_use_sqrt;
    logic [7:0]         r_d_idx;
    logic [33:0]        r_d_op, r_d_len2;
    t_item              r_item;

    logic signed [17:0] fx, fy, sx, sy, px, py;
    logic [7:0]         m;
    logic [14:0]        reff;
    t_item              n_item;

    assign fx = {{2{i_cfg.fx[15]}}, i_cfg.fx};
    assign fy = {{2{i_cfg.fy[15]}}, i_cfg.fy};
    assign sx = {{2{i_cfg.sx[15]}}, i_cfg.sx};
    assign sy = {{2{i_cfg.sy[15]}}, i_cfg.sy};
    assign px = {{(18-COORD_BITS){1'b0}}, i_pixel_x};
    assign py = {{(18-COORD_BITS){1'b0}}, i_pixel_y};
    assign reff = (i_cfg.radius == 15'd0) ? 15'd1 : i_cfg.radius;

    always_comb begin
        if (i_cfg.count == 9'd0) begin
            m = 8'd0;
        end else if (i_cfg.count > 9'd256) begin
            m = 8'd255;
        end else begin
            m = 8'(i_cfg.count - 9'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ctl.func <= i_func;
        r_a_ctl.eidx <= i_entry_index;
        r_a_ctl.esym <= i_entry_symbol;
        r_a_dx <= px - fx;
        r_a_dy <= py - fy;
        r_a_bx <= sx - fx;
        r_a_by <= sy - fy;

        r_b_ctl.func <= r_a_ctl.func;
        r_b_ctl.eidx <= r_a_ctl.eidx;
        r_b_ctl.esym <= r_a_ctl.esym;
        if (i_cfg.mode == MODE_RADIAL) begin
            r_b_pa <= r_a_dx * r_a_dx;
            r_b_pb <= r_a_dy * r_a_dy;
        end else begin
            r_b_pa <= r_a_dx * r_a_bx;
            r_b_pb <= r_a_dy * r_a_by;
        end
        r_b_pc <= r_a_bx * r_a_bx;
        r_b_pd <= r_a_by * r_a_by;
        r_b_rr <= reff * reff;
        r_b_mm <= m * m;
        r_b_m  <= m;

        r_c_ctl.func <= r_b_ctl.func;
        r_c_ctl.eidx <= r_b_ctl.eidx;
        r_c_ctl.esym <= r_b_ctl.esym;
        r_c_s1 <= 37'(r_b_pa) + 37'(r_b_pb);
        r_c_s2 <= 37'(r_b_pc) + 37'(r_b_pd);
        r_c_rr <= r_b_rr;
        r_c_mm <= r_b_mm;
        r_c_m  <= r_b_m;

        r_d_ctl.func <= r_c_ctl.func;
        r_d_ctl.eidx <= r_c_ctl.eidx;
        r_d_ctl.esym <= r_c_ctl.esym;
        r_d_mm   <= r_c_mm;
        r_d_m    <= r_c_m;
        r_d_op   <= r_c_s1[33:0];
        r_d_len2 <= r_c_s2[33:0];
        r_d_degen    <= 1'b0;
        r_d_use_sqrt <= 1'b0;
        r_d_done     <= 1'b1;
        r_d_idx      <= 8'd0;
        if (i_cfg.mode == MODE_RADIAL) begin
            if (r_c_s1 > $signed({7'd0, r_c_rr})) begin
                r_d_idx <= r_c_m;
            end else begin
                r_d_done     <= 1'b0;
                r_d_use_sqrt <= 1'b1;
            end
        end else if (r_c_s2 == 37'sd0) begin
            r_d_degen <= 1'b1;
        end else if (r_c_s1 < 37'sd0) begin
            r_d_idx <= 8'd0;
        end else if (r_c_s1 > r_c_s2) begin
            r_d_idx <= r_c_m;
        end else begin
            r_d_done <= 1'b0;
        end

        r_item.ctl.func <= n_item.ctl.func;
        r_item.ctl.eidx <= n_item.ctl.eidx;
        r_item.ctl.esym <= n_item.ctl.esym;
        r_item.use_sqrt <= n_item.use_sqrt;
        r_item.done     <= n_item.done;
        r_item.degen    <= n_item.degen;
        r_item.idx      <= n_item.idx;
        r_item.sq_v     <= n_item.sq_v;
        r_item.sq_res   <= n_item.sq_res;
        r_item.sq_bit   <= n_item.sq_bit;
        r_item.num      <= n_item.num;
        r_item.dsh      <= n_item.dsh;

        if (!i_rst_n) begin
            r_a_ctl.valid <= 1'b0;
            r_b_ctl.valid <= 1'b0;
            r_c_ctl.valid <= 1'b0;
            r_d_ctl.valid <= 1'b0;
            r_item.ctl.valid <= 1'b0;
        end else begin
            r_a_ctl.valid <= i_valid;
            r_b_ctl.valid <= r_a_ctl.valid;
            r_c_ctl.valid <= r_b_ctl.valid;
            r_d_ctl.valid <= r_c_ctl.valid;
            r_item.ctl.valid <= n_item.ctl.valid;
        end
    end

    always_comb begin
        n_item.ctl      = r_d_ctl;
        n_item.use_sqrt = r_d_use_sqrt;
        n_item.done     = r_d_done;
        n_item.degen    = r_d_degen;
        n_item.idx      = r_d_idx;
        n_item.sq_res   = 46'd0;
        n_item.sq_bit   = 46'd1 << 44;
        if (r_d_use_sqrt) begin
            n_item.sq_v = 46'(r_d_op[29:0] * r_d_mm);
            n_item.num  = 42'd0;
            n_item.dsh  = 42'(reff) << 7;
        end else begin
            n_item.sq_v = 46'd0;
            n_item.num  = 42'(r_d_op * r_d_m);
            n_item.dsh  = 42'(r_d_len2) << 7;
        end
    end

    assign o_item = r_item;

endmodule

// ===== rtl/gcs_sqrt_cell.sv =====
`timescale 1ns / 1ps
module gcs_sqrt_cell import gcs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    output t_item o_item
);

    t_item       r_item;
    t_item       n_item;
    logic [45:0] trial;

    assign trial = i_item.sq_res + i_item.sq_bit;

    always_comb begin
        n_item = i_item;
        if (i_item.ctl.valid && i_item.use_sqrt) begin
            if (i_item.sq_v >= trial) begin
                n_item.sq_v   = i_item.sq_v - trial;
                n_item.sq_res = (i_item.sq_res >> 1) + i_item.sq_bit;
            end else begin
                n_item.sq_res = i_item.sq_res >> 1;
            end
            n_item.sq_bit = i_item.sq_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.ctl.valid <= 1'b0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== rtl/gcs_div_cell.sv =====
`timescale 1ns / 1ps
module gcs_div_cell import gcs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    output t_item o_item
);

    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item = i_item;
        if (i_item.ctl.valid && !i_item.done) begin
            if (i_item.num >= i_item.dsh) begin
                n_item.num = i_item.num - i_item.dsh;
                n_item.idx = {i_item.idx[6:0], 1'b1};
            end else begin
                n_item.idx = {i_item.idx[6:0], 1'b0};
            end
            n_item.dsh = i_item.dsh >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.ctl.valid <= 1'b0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== rtl/gcs_palette.sv =====
`timescale 1ns / 1ps
module gcs_palette import gcs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    output logic       o_valid,
    output logic [7:0] o_symbol,
    output logic [7:0] o_color_index,
    output logic       o_degenerate
);

    logic [7:0] r_mem [PALETTE_DEPTH];
    logic       r_valid;
    logic [7:0] r_symbol, r_idx;
    logic       r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_item.ctl.valid && (i_item.ctl.func == FUNC_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ctl.valid && (i_item.ctl.func == FUNC_WRITE)) begin
            r_mem[i_item.ctl.eidx] <= i_item.ctl.esym;
        end
        r_symbol <= r_mem[i_item.idx[IDX_BITS-1:0]];
        r_idx    <= i_item.idx;
        r_degen  <= i_item.degen;
    end

    assign o_valid       = r_valid;
    assign o_symbol      = r_symbol;
    assign o_color_index = r_idx;
    assign o_degenerate  = r_degen;

endmodule

// ===== rtl/gradient_color_sampler_top.sv =====
`timescale 1ns / 1ps
// channel   ports                                           handshake
// config    i_cfg_we, i_cfg_idx, i_cfg_data                 write when i_cfg_we
// request   start, busy, i_func, i_pixel_x/y, i_entry_*     start && !busy
// result    o_valid, o_symbol, o_color_index, o_degenerate  o_valid, one cycle
//
// One transaction per cycle while busy is low; each result passes through the
// 5 front stages, 23 square-root cells, 8 divider cells and the palette.
// Synchronous active-low reset; busy is high in reset and the cycle after.
// The result side cannot stall; palette writes give no result.
module gradient_color_sampler_top import gcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_func,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic [IDX_BITS-1:0]   i_entry_index,
    input  logic [7:0]            i_entry_symbol,
    output logic                  o_valid,
    output logic [7:0]            o_symbol,
    output logic [7:0]            o_color_index,
    output logic                  o_degenerate
);

    t_cfg  r_cfg;
    logic  r_ready;
    t_item w_sq  [SQRT_STEPS+1];
    t_item w_div [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready      <= 1'b0;
            r_cfg.mode   <= MODE_RADIAL;
            r_cfg.fx     <= 16'sd0;
            r_cfg.fy     <= 16'sd0;
            r_cfg.radius <= 15'd1;
            r_cfg.sx     <= 16'sd0;
            r_cfg.sy     <= 16'sd0;
            r_cfg.count  <= 9'd1;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_MODE:   r_cfg.mode   <= i_cfg_data[0];
                    CFG_FX:     r_cfg.fx     <= i_cfg_data;
                    CFG_FY:     r_cfg.fy     <= i_cfg_data;
                    CFG_RADIUS: r_cfg.radius <= i_cfg_data[14:0];
                    CFG_SX:     r_cfg.sx     <= i_cfg_data;
                    CFG_SY:     r_cfg.sy     <= i_cfg_data;
                    CFG_COUNT:  r_cfg.count  <= i_cfg_data[8:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign busy = !r_ready;

    gcs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (start && r_ready),
        .i_func         (i_func),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_entry_index  (i_entry_index),
        .i_entry_symbol (i_entry_symbol),
        .o_item         (w_sq[0])
    );

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        gcs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (w_sq[g]),
            .o_item  (w_sq[g+1])
        );
    end

    always_comb begin
        w_div[0] = w_sq[SQRT_STEPS];
        if (w_sq[SQRT_STEPS].use_sqrt) begin
            w_div[0].num = w_sq[SQRT_STEPS].sq_res[41:0];
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        gcs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (w_div[g]),
            .o_item  (w_div[g+1])
        );
    end

    gcs_palette u_palette (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_div[DIV_STEPS]),
        .o_valid       (o_valid),
        .o_symbol      (o_symbol),
        .o_color_index (o_color_index),
        .o_degenerate  (o_degenerate)
    );

endmodule

// ===== rtl/gcs_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gcs_checker import gcs_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_func,
    input logic       o_valid,
    input logic [7:0] o_color_index,
    input logic       o_degenerate
);

    `ASSERT_NEXT(a_busy_in_reset, i_clk, !i_rst_n, busy)
    `ASSERT_NEXT(a_no_result_after_reset, i_clk, !i_rst_n, !o_valid)
    `ASSERT_IMPL(a_result_has_request, i_clk, i_rst_n, o_valid, $past(start && !busy && i_func, LATENCY))
    `ASSERT_IMPL(a_degenerate_index, i_clk, i_rst_n, o_valid && o_degenerate, o_color_index == 8'd0)

endmodule

bind gradient_color_sampler_top gcs_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_func        (i_func),
    .o_valid       (o_valid),
    .o_color_index (o_color_index),
    .o_degenerate  (o_degenerate)
);
